/* hdl/sok_pkg.sv */
// Shared constants and control/status types for the stochastic oscillator %K unit.
`default_nettype none
package sok_pkg;

  // Default sizing handed to the top level parameters
  localparam int WINDOW_MAX_DEF = 64;
  localparam int PRICE_BITS_DEF = 32;

  // Port widths
  localparam int IN_W  = 32;
  localparam int CFG_W = 7;
  localparam int PK_W  = 15;

  // Window length after reset
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd14;

  // 100 percent in Q7.8
  localparam logic [PK_W-1:0] K_FULL = 15'd25600;

  // Quotient bits produced by the serial divider, one per cycle
  localparam int Q_BITS    = PK_W;
  localparam int DIV_CNT_W = $clog2(Q_BITS);

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // load bar, write ring, bump counters
    logic rd_en;     // issue one ring read, step pointer back
    logic acc_en;    // fold returned ring word into extremes
    logic mul_en;    // form dividend and divisor
    logic div_step;  // one restoring divide step
    logic res_load;  // load the output word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic win_ready; // enough bars held for the current window
    logic flat;      // highest high does not exceed lowest low
    logic clip;      // close outside the range
  } sts_t;

endpackage
`default_nettype wire

/* hdl/sok_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sok_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/sok_dp.sv */
// Datapath: ring store, extreme scan, classification, serial divider, output word.
`default_nettype none
module sok_dp #(
  parameter int WINDOW_MAX = sok_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = sok_pkg::PRICE_BITS_DEF,
  localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sok_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic [sok_pkg::IN_W-1:0]  in_high_price,
  input  wire logic [sok_pkg::IN_W-1:0]  in_low_price,
  input  wire logic [sok_pkg::IN_W-1:0]  in_close_price,
  input  wire sok_pkg::cmd_t             cmd,
  output sok_pkg::sts_t                  sts,
  output logic      [LEN_W-1:0]          len,
  output logic      [sok_pkg::PK_W-1:0]  out_percent_k,
  output logic                           out_window_ready,
  output logic                           out_flat_range,
  output logic                           out_clipped
);

  localparam int PW    = PRICE_BITS;
  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CW    = (LEN_W > sok_pkg::CFG_W) ? LEN_W : sok_pkg::CFG_W;
  localparam int NUM_W = PW + sok_pkg::Q_BITS;

  logic [sok_pkg::CFG_W-1:0] window_length_r;
  logic [AW-1:0]             write_slot_r, write_slot_nxt;
  logic [AW-1:0]             rd_ptr_r;
  logic [LEN_W-1:0]          bars_held_r, bars_held_nxt;
  logic [LEN_W-1:0]          len_r;
  logic                      win_ready_r;
  logic [PW-1:0]             close_r, hmax_r, lmin_r;
  logic [NUM_W-1:0]          rem_r, dvs_r;
  logic [sok_pkg::Q_BITS-1:0] quot_r;
  logic [sok_pkg::PK_W-1:0]  pk_r;
  logic                      rdy_r, flat_r, clip_r;

  logic [PW+sok_pkg::IN_W-1:0] hi_ext, lo_ext, cl_ext;
  logic [PW-1:0]             hi_in, lo_in, cl_in;
  logic [2*PW-1:0]           rd_data;
  logic [PW-1:0]             rd_hi, rd_lo;
  logic [CW-1:0]             cfg_ext, eff_len;
  logic                      clip_lo, clip_hi;
  logic [PW-1:0]             span, offset;
  logic [NUM_W-1:0]          off_ext, dividend;
  logic [sok_pkg::PK_W-1:0]  quot_sat;

  // Keep the low PRICE_BITS of each price, zero-extending if wider than the port
  assign hi_ext = {{PW{1'b0}}, in_high_price};
  assign lo_ext = {{PW{1'b0}}, in_low_price};
  assign cl_ext = {{PW{1'b0}}, in_close_price};
  assign hi_in  = hi_ext[PW-1:0];
  assign lo_in  = lo_ext[PW-1:0];
  assign cl_in  = cl_ext[PW-1:0];

  // Effective window: zero counts as one, clamp at ring depth
  assign cfg_ext = CW'(window_length_r);
  always_comb begin
    if (cfg_ext == '0) begin
      eff_len = CW'(1);
    end else if (cfg_ext > CW'(WINDOW_MAX)) begin
      eff_len = CW'(WINDOW_MAX);
    end else begin
      eff_len = cfg_ext;
    end
  end

  // Ring pointer and fill count
  assign write_slot_nxt = (write_slot_r == AW'(WINDOW_MAX - 1)) ? '0 : write_slot_r + 1'b1;
  assign bars_held_nxt  = (bars_held_r == LEN_W'(WINDOW_MAX)) ? bars_held_r
                                                               : bars_held_r + 1'b1;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= sok_pkg::WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_length_r <= cfg_wr_data;
    end
  end

  // Control counters of the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      bars_held_r  <= '0;
      win_ready_r  <= 1'b0;
    end else if (cmd.accept) begin
      write_slot_r <= write_slot_nxt;
      bars_held_r  <= bars_held_nxt;
      win_ready_r  <= (CW'(bars_held_nxt) >= eff_len);
    end
  end

  // High and low rings share one RAM word
  sok_ram #(
    .WIDTH (2 * PW),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (write_slot_r),
    .wr_data ({hi_in, lo_in}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  assign rd_hi = rd_data[2*PW-1:PW];
  assign rd_lo = rd_data[PW-1:0];

  // Bar capture, newest-first read pointer, running extremes
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      close_r  <= cl_in;
      len_r    <= LEN_W'(eff_len);
      rd_ptr_r <= write_slot_r;
      hmax_r   <= '0;
      lmin_r   <= '1;
    end else begin
      if (cmd.rd_en) begin
        rd_ptr_r <= (rd_ptr_r == '0) ? AW'(WINDOW_MAX - 1) : rd_ptr_r - 1'b1;
      end
      if (cmd.acc_en) begin
        if (rd_hi > hmax_r) begin
          hmax_r <= rd_hi;
        end
        if (rd_lo < lmin_r) begin
          lmin_r <= rd_lo;
        end
      end
    end
  end

  // Classification of close against the range
  assign clip_lo = (close_r < lmin_r);
  assign clip_hi = (close_r > hmax_r);
  assign span    = hmax_r - lmin_r;
  assign offset  = close_r - lmin_r;

  // offset * 25600 as shifted adds: 25600 = 2^14 + 2^13 + 2^10
  assign off_ext  = NUM_W'(offset);
  assign dividend = (off_ext << 14) + (off_ext << 13) + (off_ext << 10);

  // Restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      rem_r  <= dividend;
      dvs_r  <= NUM_W'(span) << (sok_pkg::Q_BITS - 1);
      quot_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r  <= rem_r - dvs_r;
        quot_r <= {quot_r[sok_pkg::Q_BITS-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[sok_pkg::Q_BITS-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
  end

  assign quot_sat = (quot_r > sok_pkg::K_FULL) ? sok_pkg::K_FULL : quot_r;

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rdy_r  <= win_ready_r;
      flat_r <= 1'b0;
      clip_r <= 1'b0;
      pk_r   <= '0;
      if (win_ready_r) begin
        if (sts.flat) begin
          flat_r <= 1'b1;
        end else if (clip_lo) begin
          clip_r <= 1'b1;
        end else if (clip_hi) begin
          clip_r <= 1'b1;
          pk_r   <= sok_pkg::K_FULL;
        end else begin
          pk_r   <= quot_sat;
        end
      end
    end
  end

  assign sts.win_ready    = win_ready_r;
  assign sts.flat         = (hmax_r <= lmin_r);
  assign sts.clip         = clip_lo | clip_hi;
  assign len              = len_r;
  assign out_percent_k    = pk_r;
  assign out_window_ready = rdy_r;
  assign out_flat_range   = flat_r;
  assign out_clipped      = clip_r;

  // Output word stays in range and flags are consistent
  a_pk_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.res_load) |-> (pk_r <= sok_pkg::K_FULL))
    else $error("percent_k above full scale");

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.res_load) && flat_r |-> (pk_r == '0) && !clip_r && rdy_r)
    else $error("flat range with nonzero result or clip");

  a_notready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.res_load) && !rdy_r |-> (pk_r == '0) && !flat_r && !clip_r)
    else $error("result before window full is not all zero");

endmodule
`default_nettype wire

/* hdl/sok_ctrl.sv */
// Controller: sequences bar capture, ring scan, divide and result hand-off.
`default_nettype none
module sok_ctrl #(
  parameter int WINDOW_MAX = sok_pkg::WINDOW_MAX_DEF,
  localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire sok_pkg::sts_t    sts,
  input  wire logic [LEN_W-1:0] len,
  output sok_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_CLASS,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [LEN_W-1:0]             scan_cnt_r, scan_cnt_nxt;
  logic [sok_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                         acc_vld_r;
  logic                         out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.acc_en   = acc_vld_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        scan_cnt_nxt = '0;
        state_nxt    = sts.win_ready ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == len - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        state_nxt = (sts.flat || sts.clip) ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == sok_pkg::DIV_CNT_W'(sok_pkg::Q_BITS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word valid: set on load, cleared when taken
  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      div_cnt_r   <= '0;
      acc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      acc_vld_r   <= cmd.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Never overwrite an output word that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten");

  // Every ring read is folded into the extremes the next cycle
  a_read_folded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> cmd.acc_en)
    else $error("ring read not accumulated");

  // Scan never runs past the window
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r < len))
    else $error("scan beyond window length");

  // No new bar taken while a bar is still in work
  a_one_bar: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !cmd.accept)
    else $error("bar accepted while busy");

endmodule
`default_nettype wire

/* hdl/stochastic_oscillator_k_unit.sv */
// Top level of the stochastic oscillator %K unit: controller plus datapath.
//
//  channel  direction  handshake                     payload
//  in       sink       in_valid / in_stall           high, low, close price (32 b each)
//  out      source     out_valid / out_stall         percent_k (15 b), 3 flags
//  cfg      sink       cfg_wr_en                     window_length (7 b)
//
// A bar with a full window takes one ring RAM read per bar of the window, then the
// bit-serial divider. A bar before the window is full skips the scan and the divider;
// one with a flat or clipped range is scanned but skips the divider.
// Reset is synchronous; ring contents need no clearing, only counters reset.
// One bar is in work at a time; the next bar is taken while a result waits on out_stall.
`default_nettype none
module stochastic_oscillator_k_unit #(
  parameter int WINDOW_MAX = sok_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = sok_pkg::PRICE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [sok_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [sok_pkg::IN_W-1:0]  in_high_price,
  input  wire logic [sok_pkg::IN_W-1:0]  in_low_price,
  input  wire logic [sok_pkg::IN_W-1:0]  in_close_price,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [sok_pkg::PK_W-1:0]  out_percent_k,
  output logic                           out_window_ready,
  output logic                           out_flat_range,
  output logic                           out_clipped
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);

  sok_pkg::cmd_t    cmd;
  sok_pkg::sts_t    sts;
  logic [LEN_W-1:0] len;

  // Sequencer
  sok_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .len       (len),
    .cmd       (cmd)
  );

  // Ring, extremes and divider
  sok_dp #(
    .WINDOW_MAX (WINDOW_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_high_price    (in_high_price),
    .in_low_price     (in_low_price),
    .in_close_price   (in_close_price),
    .cmd              (cmd),
    .sts              (sts),
    .len              (len),
    .out_percent_k    (out_percent_k),
    .out_window_ready (out_window_ready),
    .out_flat_range   (out_flat_range),
    .out_clipped      (out_clipped)
  );

endmodule
`default_nettype wire

/* dv/stochastic_oscillator_k_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for the stochastic oscillator %K unit: directed and random bars checked by a predictor.
module stochastic_oscillator_k_unit_tb;

  localparam int RING_DEPTH = sok_pkg::WINDOW_MAX_DEF;
  localparam int WDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int CFG_SETTLE = 8;
  localparam int BARS_PER_WINDOW = 75;

  // One result word as the block reports it
  typedef struct packed {
    logic [sok_pkg::PK_W-1:0] percent_k;
    logic                     window_ready;
    logic                     flat_range;
    logic                     clipped;
  } k_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [sok_pkg::CFG_W-1:0] cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [sok_pkg::IN_W-1:0]  in_high_price = '0;
  logic [sok_pkg::IN_W-1:0]  in_low_price = '0;
  logic [sok_pkg::IN_W-1:0]  in_close_price = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [sok_pkg::PK_W-1:0]  out_percent_k;
  logic                      out_window_ready;
  logic                      out_flat_range;
  logic                      out_clipped;

  // Predictor state: price rings, slot pointer, bar count, window setting
  logic [sok_pkg::IN_W-1:0]  hi_ring [RING_DEPTH];
  logic [sok_pkg::IN_W-1:0]  lo_ring [RING_DEPTH];
  int unsigned               next_slot = 0;
  int unsigned               bars_seen = 0;
  logic [sok_pkg::CFG_W-1:0] win_len = sok_pkg::WINDOW_RESET;
  k_word_t                   k_expected [$];
  k_word_t                   k_want;

  int unsigned               err_cnt = 0;
  int unsigned               send_gap_pct = 37;
  int unsigned               stall_pct = 37;
  logic                      hold_req = 1'b0;
  int unsigned               hold_left = 0;
  int unsigned               idle_cycles = 0;
  logic [sok_pkg::IN_W-1:0]  walk_mid = 32'd100000;

  stochastic_oscillator_k_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_high_price    (in_high_price),
    .in_low_price     (in_low_price),
    .in_close_price   (in_close_price),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_percent_k    (out_percent_k),
    .out_window_ready (out_window_ready),
    .out_flat_range   (out_flat_range),
    .out_clipped      (out_clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store the bar, then %K over the last window of bars
  function automatic k_word_t predict_k(logic [sok_pkg::IN_W-1:0] h,
                                        logic [sok_pkg::IN_W-1:0] l,
                                        logic [sok_pkg::IN_W-1:0] c);
    int unsigned              span;
    int unsigned              idx;
    logic [sok_pkg::IN_W-1:0] hmax;
    logic [sok_pkg::IN_W-1:0] lmin;
    logic [63:0]              quo;
    k_word_t                  r;
    hi_ring[next_slot] = h;
    lo_ring[next_slot] = l;
    next_slot = (next_slot + 1) % RING_DEPTH;
    if (bars_seen < RING_DEPTH) bars_seen++;
    // zero acts as one, above the ring depth acts as the depth
    span = (win_len == 0) ? 1 : (win_len > RING_DEPTH) ? RING_DEPTH : win_len;
    r = '0;
    if (bars_seen < span) return r;
    hmax = '0;
    lmin = '1;
    for (int k = 0; k < span; k++) begin
      idx = (next_slot + RING_DEPTH - 1 - k) % RING_DEPTH;
      if (hi_ring[idx] > hmax) hmax = hi_ring[idx];
      if (lo_ring[idx] < lmin) lmin = lo_ring[idx];
    end
    r.window_ready = 1'b1;
    if (hmax <= lmin) begin
      r.flat_range = 1'b1;  // flat or inverted range
    end else if (c < lmin) begin
      r.clipped = 1'b1;
    end else if (c > hmax) begin
      r.clipped = 1'b1;
      r.percent_k = sok_pkg::K_FULL;
    end else begin
      quo = (64'(c - lmin) * 64'(sok_pkg::K_FULL)) / 64'(hmax - lmin);
      r.percent_k = quo[sok_pkg::PK_W-1:0];
    end
    return r;
  endfunction

  // Offer one bar after a random gap; valid stays up on return
  task automatic send_bar(input logic [sok_pkg::IN_W-1:0] h,
                          input logic [sok_pkg::IN_W-1:0] l,
                          input logic [sok_pkg::IN_W-1:0] c);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_high_price  <= h;
    in_low_price   <= l;
    in_close_price <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    k_expected.push_back(predict_k(h, l, c));
  endtask

  // Stop offering and let every result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (k_expected.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [sok_pkg::CFG_W-1:0] len);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = len;
  endtask

  // Mostly a drifting market with random bar spread; some noise and flat bars
  task automatic send_random_bar();
    int unsigned              pick;
    logic [sok_pkg::IN_W-1:0] up;
    logic [sok_pkg::IN_W-1:0] dn;
    logic [sok_pkg::IN_W:0]   top;
    logic [sok_pkg::IN_W-1:0] h;
    logic [sok_pkg::IN_W-1:0] l;
    logic [sok_pkg::IN_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise, often an inverted bar
      h = $urandom;
      l = $urandom;
      c = $urandom;
    end else if (pick < 12) begin
      h = $urandom;
      l = h;
      c = $urandom_range(1) ? h : $urandom;
    end else begin
      if ($urandom_range(39) == 0) begin
        case ($urandom_range(2))
          0: walk_mid = $urandom_range(500);
          1: walk_mid = 32'hFFFF_FFFF - $urandom_range(500);
          default: walk_mid = $urandom;
        endcase
      end
      // random walk with saturation
      up = $urandom_range(300);
      top = {1'b0, walk_mid} + up;
      if ($urandom_range(1)) walk_mid = top[sok_pkg::IN_W] ? '1 : top[sok_pkg::IN_W-1:0];
      else walk_mid = (walk_mid < up) ? '0 : walk_mid - up;
      up = ($urandom_range(19) == 0) ? $urandom : $urandom_range(2000);
      dn = ($urandom_range(19) == 0) ? $urandom : $urandom_range(2000);
      top = {1'b0, walk_mid} + up;
      h = top[sok_pkg::IN_W] ? '1 : top[sok_pkg::IN_W-1:0];
      l = (walk_mid < dn) ? '0 : walk_mid - dn;
      pick = $urandom_range(99);
      if (pick < 8 && l != 0) c = $urandom_range(l - 1, 0);
      else if (pick < 16 && h != '1) c = $urandom_range(32'hFFFF_FFFF, h + 1);
      else c = l + sok_pkg::IN_W'({$urandom, $urandom} % (64'(h - l) + 64'd1));
    end
    send_bar(h, l, c);
  endtask

  // Before the window fills, all fields read zero
  task automatic test_window_filling();
    send_bar('1, '1, '1);
    send_bar('0, '0, '0);
    send_bar('1, '0, 32'h5A5A_A5A5);
  endtask

  // Single bar window: extremes, flat, inverted and clipped bars
  task automatic test_special_bars();
    write_window(7'd1);
    send_bar('1, '0, '1);
    send_bar('1, '0, '0);
    send_bar('1, '0, 32'h8000_0000);
    send_bar('0, '0, '0);
    send_bar('1, '1, '0);
    send_bar(32'd100, 32'd200, 32'd150);
    send_bar(32'd1000, 32'd500, 32'd10);
    send_bar(32'd1000, 32'd500, 32'd5000);
    send_bar(32'd1000, 32'd500, 32'd777);
  endtask

  // Zero length acts as one, oversize length as the ring depth
  task automatic test_length_clamping();
    write_window(7'd0);
    send_bar(32'd40, 32'd20, 32'd30);
    send_bar(32'd90, 32'd10, 32'd85);
    write_window(7'd127);
    send_bar(32'd70, 32'd60, 32'd65);
    send_bar(32'd80, 32'd50, 32'd55);
  endtask

  task automatic test_random_windows();
    logic [sok_pkg::CFG_W-1:0] lengths [8];
    lengths = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd14, 7'd63, 7'd0};
    lengths[7] = sok_pkg::CFG_W'($urandom_range(127));
    foreach (lengths[i]) begin
      write_window(lengths[i]);
      repeat (BARS_PER_WINDOW) send_random_bar();
    end
  endtask

  // Full rate on both sides, then a long receiver hold while bars keep coming
  task automatic test_back_pressure();
    write_window(7'd5);
    send_gap_pct = 0;
    stall_pct = 0;
    repeat (25) send_random_bar();
    hold_req <= 1'b1;
    repeat (25) send_random_bar();
    send_gap_pct = 37;
    stall_pct = 37;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_filling();
    test_special_bars();
    test_length_clamping();
    test_random_windows();
    test_back_pressure();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** stochastic_oscillator_k_unit: PASSED **");
    end else begin
      $display("** stochastic_oscillator_k_unit: FAILED **");
    end
    $finish;
  end

  // Receiver stall: random, or a long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (k_expected.size() == 0) begin
        $error("unexpected result word: percent_k %0d", out_percent_k);
        err_cnt++;
      end else begin
        k_want = k_expected.pop_front();
        if (out_percent_k !== k_want.percent_k) begin
          $error("percent_k: expected %0d, got %0d", k_want.percent_k, out_percent_k);
          err_cnt++;
        end
        if (out_window_ready !== k_want.window_ready) begin
          $error("window_ready: expected %0b, got %0b", k_want.window_ready,
                 out_window_ready);
          err_cnt++;
        end
        if (out_flat_range !== k_want.flat_range) begin
          $error("flat_range: expected %0b, got %0b", k_want.flat_range, out_flat_range);
          err_cnt++;
        end
        if (out_clipped !== k_want.clipped) begin
          $error("clipped: expected %0b, got %0b", k_want.clipped, out_clipped);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WDOG_LIMIT) begin
      $display("** stochastic_oscillator_k_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
